### rtl/rcss_pkg.sv
// ----------------------------------------------------------------------------
// rcss_pkg
// Shared types, constants and helpers of the radio stick rate shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package rcss_pkg;

    localparam int NumAxes = 3;   // roll, pitch and yaw lanes
    localparam int RawW   = 12;   // pulse width fields
    localparam int DeltaW = 10;   // clamped stick delta, -500..500
    localparam int MagW   = 9;    // |delta|, 0..500
    localparam int RateW  = 23;   // Q4 deg/s result
    localparam int ThrW   = 13;   // throttle Q12, 0..4096
    localparam int RsW    = 11;
    localparam int SfW    = 7;
    localparam int ProdW  = RsW + MagW;   // rate_scale * |d|
    localparam int SfmW   = 16;           // superfactor * |d|, below 65536
    localparam int NumW   = 31;           // 1600 * rate_scale * |d|
    localparam int DenW   = 16;           // 500..50000
    localparam int CntW   = 5;
    localparam int QuoW   = 22;           // quotient magnitude fits 22 bits

    localparam int StickSpan = 500;
    localparam logic [DenW-1:0] DenOne = 16'd50000;
    localparam logic [DenW-1:0] DenMin = 16'd500;
    localparam logic [SfmW-1:0] SfmMax = 16'd49500;  // above this the floor applies
    localparam logic [10:0] NumScale = 11'd1600;      // 16 (Q4) times 100
    // floor(x / 125) for x below 2^19 equals (x * ThrRecip) >> 26.
    localparam logic [19:0] ThrRecip = 20'd536871;
    localparam int ThrShift = 26;

    localparam logic [2:0] CfgCenter    = 3'd0;
    localparam logic [2:0] CfgThreshold = 3'd1;
    localparam logic [2:0] CfgRateScale = 3'd2;
    localparam logic [2:0] CfgSuperPct  = 3'd3;

    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_MUL,
        LANE_PREP,
        LANE_DIV
    } lane_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_RUN
    } top_state_t;

    typedef struct packed {
        logic                    busy;
        logic signed [RateW-1:0] rate;
    } lane_stat_t;

    // Center subtraction and clamp to +-500.
    function automatic logic signed [DeltaW-1:0] stick_delta(
        input logic [RawW-1:0] raw,
        input logic [RawW-1:0] center
    );
        logic signed [RawW:0] diff;
        logic signed [DeltaW-1:0] res;
        diff = $signed({1'b0, raw}) - $signed({1'b0, center});
        if (diff < -13'sd500) begin
            res = -10'sd500;
        end
        else if (diff > 13'sd500) begin
            res = 10'sd500;
        end
        else begin
            res = diff[DeltaW-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/rcss_lane.sv
// ----------------------------------------------------------------------------
// rcss_lane
// One axis: stick delta, superfactor denominator and a bit-serial restoring
// divider that yields the Q4 rate truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rcss_lane (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [rcss_pkg::RawW-1:0]        raw_us,
    input  wire logic [rcss_pkg::RawW-1:0]        center_us,
    input  wire logic [rcss_pkg::RsW-1:0]         rate_scale,
    input  wire logic [rcss_pkg::SfW-1:0]         superfactor_pct,
    output rcss_pkg::lane_stat_t                  stat
);

    rcss_pkg::lane_state_t state_reg, state_next;

    logic                            neg_reg;
    logic [rcss_pkg::MagW-1:0]       mag_reg;
    logic [rcss_pkg::ProdW-1:0]      prod_reg;
    logic [rcss_pkg::SfmW-1:0]       sfm_reg;
    logic [rcss_pkg::NumW-1:0]       nq_reg;
    logic [rcss_pkg::DenW-1:0]       den_reg;
    logic [rcss_pkg::DenW-1:0]       rem_reg;
    logic [rcss_pkg::CntW-1:0]       cnt_reg;

    logic signed [rcss_pkg::DeltaW-1:0] delta;
    logic [rcss_pkg::DenW:0]            trial;
    logic [rcss_pkg::DenW:0]            diff;
    logic                               qbit;
    logic [rcss_pkg::RateW-1:0]         qmag;

    assign delta = rcss_pkg::stick_delta(raw_us, center_us);

    // One restoring step: bring down the next numerator bit.
    assign trial = {rem_reg, nq_reg[rcss_pkg::NumW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcss_pkg::LANE_IDLE:
            begin
                if (start)
                begin
                    state_next = rcss_pkg::LANE_MUL;
                end
            end
            rcss_pkg::LANE_MUL:  state_next = rcss_pkg::LANE_PREP;
            rcss_pkg::LANE_PREP: state_next = rcss_pkg::LANE_DIV;
            rcss_pkg::LANE_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = rcss_pkg::LANE_IDLE;
                end
            end
            default: state_next = rcss_pkg::LANE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcss_pkg::LANE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rcss_pkg::LANE_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= delta[rcss_pkg::DeltaW-1];
                    mag_reg <= delta[rcss_pkg::DeltaW-1] ?
                               rcss_pkg::MagW'(-delta) : rcss_pkg::MagW'(delta);
                end
            end
            rcss_pkg::LANE_MUL:
            begin
                prod_reg <= rcss_pkg::ProdW'(rate_scale) * rcss_pkg::ProdW'(mag_reg);
                sfm_reg  <= rcss_pkg::SfmW'(superfactor_pct) * rcss_pkg::SfmW'(mag_reg);
            end
            rcss_pkg::LANE_PREP:
            begin
                nq_reg  <= rcss_pkg::NumW'(prod_reg) * rcss_pkg::NumW'(rcss_pkg::NumScale);
                den_reg <= (sfm_reg >= rcss_pkg::SfmMax) ? rcss_pkg::DenMin
                                                         : rcss_pkg::DenOne - sfm_reg;
                rem_reg <= '0;
                cnt_reg <= rcss_pkg::CntW'(rcss_pkg::NumW - 1);
            end
            rcss_pkg::LANE_DIV:
            begin
                rem_reg <= qbit ? diff[rcss_pkg::DenW-1:0] : trial[rcss_pkg::DenW-1:0];
                nq_reg  <= {nq_reg[rcss_pkg::NumW-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_comb
    begin
        qmag      = {1'b0, nq_reg[rcss_pkg::QuoW-1:0]};
        stat.busy = (state_reg != rcss_pkg::LANE_IDLE);
        stat.rate = neg_reg ? $signed(-qmag) : $signed(qmag);
    end

endmodule

`default_nettype wire

### rtl/rcss_merge.sv
// ----------------------------------------------------------------------------
// rcss_merge
// Maps the throttle to Q12 and keeps the armed state that gates the arm
// event pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module rcss_merge (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         commit,
    input  wire logic [rcss_pkg::RawW-1:0]    throttle_us,
    input  wire logic [rcss_pkg::RawW-1:0]    arm_switch_us,
    input  wire logic [rcss_pkg::RawW-1:0]    center_us,
    input  wire logic [rcss_pkg::RawW-1:0]    arm_threshold_us,
    output logic      [rcss_pkg::ThrW-1:0]    throttle_q12,
    output logic                              armed_next,
    output logic                              arm_event
);

    logic                               armed_reg;
    logic signed [rcss_pkg::DeltaW-1:0] dt;
    logic [rcss_pkg::DeltaW-1:0]        shifted;
    logic [38:0]                        thr_prod;
    logic                               request;
    logic                               down;

    assign dt      = rcss_pkg::stick_delta(throttle_us, center_us);
    assign shifted = rcss_pkg::DeltaW'(dt + 10'sd500);

    // (dt + 500) * 4096 / 1000 is (dt + 500) * 512 / 125, done by reciprocal.
    assign thr_prod     = 39'({shifted, 9'd0}) * 39'(rcss_pkg::ThrRecip);
    assign throttle_q12 = thr_prod[rcss_pkg::ThrShift +: rcss_pkg::ThrW];

    assign request    = (arm_switch_us >= arm_threshold_us);
    assign down       = (dt == -10'sd500);
    assign armed_next = request && (armed_reg || down);
    assign arm_event  = request && !armed_reg && down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
        end
        else if (commit)
        begin
            armed_reg <= armed_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rc_stick_rate_shaper.sv
// ----------------------------------------------------------------------------
// rc_stick_rate_shaper
// Radio stick shaping: throttle to Q12, three axes through a rate and
// superfactor curve in Q4 deg/s, and arm handling with an arm event pulse.
//
//   Port group   Dir  Beat contents
//   s_*          in   one radio frame (five pulse widths)
//   m_*          out  throttle, three rates, armed flag, arm event
//   cfg_*        in   register write, no wait and no read-back
//
// A frame passes from acceptance through the multiply, prepare and 31-step
// bit-serial divide states of each axis lane before its result enters the
// output register. The three lanes run side by side, and the next frame can
// be taken in the cycle after the previous result is loaded, not before.
// A stalled output holds the finished lane results until the output register
// frees. Reset is asynchronous, active low, returns the state, valid and
// configuration registers to their defaults and disarms.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_stick_rate_shaper (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // throttle_us[11:0], roll_us[23:12], pitch_us[35:24], yaw_us[47:36],
    // arm_switch_us[59:48], zero fill [63:60]
    input  wire logic [63:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // throttle_q12[12:0], roll_rate[35:13], pitch_rate[58:36],
    // yaw_rate[81:59], is_armed[82], arm_event[83], zero fill [87:84]
    output logic      [87:0]  m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [11:0]  cfg_data
);

    rcss_pkg::top_state_t state_reg, state_next;

    logic [rcss_pkg::RawW-1:0] center_reg;
    logic [rcss_pkg::RawW-1:0] threshold_reg;
    logic [rcss_pkg::RsW-1:0]  rate_scale_reg;
    logic [rcss_pkg::SfW-1:0]  superpct_reg;

    logic [rcss_pkg::RawW-1:0] throttle_reg;
    logic [rcss_pkg::RawW-1:0] switch_reg;

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    rcss_pkg::lane_stat_t            lane_stat [rcss_pkg::NumAxes];
    logic [rcss_pkg::NumAxes-1:0]    lane_busy;
    logic                            accept;
    logic                            commit;
    logic                            any_busy;
    logic [rcss_pkg::ThrW-1:0]       throttle_q12;
    logic                            armed_next;
    logic                            arm_event;

    assign accept = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g < rcss_pkg::NumAxes; g++)
        begin : g_lane
            rcss_lane u_lane (
                .clk             (clk),
                .rst_n           (rst_n),
                .start           (accept),
                .raw_us          (s_tdata[(g + 1) * rcss_pkg::RawW +: rcss_pkg::RawW]),
                .center_us       (center_reg),
                .rate_scale      (rate_scale_reg),
                .superfactor_pct (superpct_reg),
                .stat            (lane_stat[g])
            );
            assign lane_busy[g] = lane_stat[g].busy;
        end
    endgenerate

    assign any_busy = |lane_busy;
    assign commit   = (state_reg == rcss_pkg::TOP_RUN) && !any_busy
                      && (!m_tvalid_reg || m_tready);

    rcss_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .commit           (commit),
        .throttle_us      (throttle_reg),
        .arm_switch_us    (switch_reg),
        .center_us        (center_reg),
        .arm_threshold_us (threshold_reg),
        .throttle_q12     (throttle_q12),
        .armed_next       (armed_next),
        .arm_event        (arm_event)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= 12'd1500;
            threshold_reg  <= 12'd1500;
            rate_scale_reg <= 11'd200;
            superpct_reg   <= 7'd70;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcss_pkg::CfgCenter:    center_reg     <= cfg_data;
                rcss_pkg::CfgThreshold: threshold_reg  <= cfg_data;
                rcss_pkg::CfgRateScale: rate_scale_reg <= cfg_data[rcss_pkg::RsW-1:0];
                rcss_pkg::CfgSuperPct:  superpct_reg   <= cfg_data[rcss_pkg::SfW-1:0];
                default:                center_reg     <= center_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcss_pkg::TOP_IDLE:
            begin
                if (accept)
                begin
                    state_next = rcss_pkg::TOP_RUN;
                end
            end
            rcss_pkg::TOP_RUN:
            begin
                if (commit)
                begin
                    state_next = rcss_pkg::TOP_IDLE;
                end
            end
            default: state_next = rcss_pkg::TOP_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == rcss_pkg::TOP_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rcss_pkg::TOP_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            throttle_reg <= s_tdata[rcss_pkg::RawW-1:0];
            switch_reg   <= s_tdata[4 * rcss_pkg::RawW +: rcss_pkg::RawW];
        end
        if (commit)
        begin
            m_tdata_reg <= {4'd0, arm_event, armed_next,
                            lane_stat[2].rate, lane_stat[1].rate, lane_stat[0].rate,
                            throttle_q12};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A new frame is only taken when every lane has finished the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !any_busy)
        else $error("frame accepted while a lane is busy");

    // Loading a result always presents a beat on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("committed result not presented");

    // An arm event can only be reported together with the armed flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[83] || m_tdata[82]))
        else $error("arm event without armed flag");

    // The lanes start together, so they finish together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lane_busy == '0) || (lane_busy == '1))
        else $error("lanes out of step");

endmodule

`default_nettype wire
